// ===== sv/utf8_text_normalizer_core_assert.svh =====
// Assertion macros for the UTF-8 text normalizer checker.
// Expects clk and arst_n to be visible where the macros are used.
`ifndef UTF8_TEXT_NORMALIZER_CORE_ASSERT_SVH
`define UTF8_TEXT_NORMALIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("normalizer check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("normalizer check failed");

`endif

// ===== sv/utf8n_pkg.sv =====
// Shared types and constants of the UTF-8 text normalizer.
// No dependencies.
package utf8n_pkg;

	localparam int MAX_RES     = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [20:0] FW_FIRST   = 21'h00FF01;
	localparam logic [20:0] FW_LAST    = 21'h00FF5E;
	localparam logic [20:0] FW_OFFSET  = 21'h00FEE0;
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] IDEO_SPACE = 21'h003000;
	localparam logic [20:0] IDEO_COMMA = 21'h003001;
	localparam logic [20:0] IDEO_STOP  = 21'h003002;
	localparam logic [20:0] FW_COMMA   = 21'h00FF0C;
	localparam logic [20:0] FW_SEMI    = 21'h00FF1B;
	localparam logic [20:0] FW_COLON   = 21'h00FF1A;

	localparam logic [7:0] SPACE_BYTE = 8'h20;

	// One queued job: the bytes caused by one input item.
	// n == 0 only for the empty end marker.
	typedef struct packed {
		logic [MAX_RES-1:0][7:0] bytes;
		logic [2:0]              n;
		logic                    text_end;
	} utf8n_job_t;

endpackage

// ===== sv/utf8_text_normalizer_core.sv =====
// A result is written into a job queue entry and then into the output register before it is on the ports.
// Throughput: one input byte per cycle while each yields at most one result and
// pop keeps pace; an item with k results holds the output sequencer for k
// transfers, and the two-entry job queue absorbs short bursts before full rises.
// Reset: arst_n clears decoder state, queue pointers and the output valid flag.
// Top level of the UTF-8 text normalizer; depends on utf8n_pkg and submodules.
module utf8_text_normalizer_core import utf8n_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_present,
	output logic       text_end,
	output logic       run_last
);

	utf8n_job_t wr_job;
	utf8n_job_t head;
	logic       job_wr;
	logic       q_empty;
	logic       q_rd;

	utf8n_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.q_full      (full),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.job_wr      (job_wr),
		.job         (wr_job)
	);

	utf8n_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (job_wr),
		.wr_job  (wr_job),
		.q_full  (full),
		.rd      (q_rd),
		.rd_job  (head),
		.q_empty (q_empty)
	);

	utf8n_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.q_rd         (q_rd),
		.pop          (pop),
		.empty        (empty),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.text_end     (text_end),
		.run_last     (run_last)
	);

endmodule

// ===== sv/utf8n_front.sv =====
// Front end: UTF-8 decode, validation, fullwidth folding, ASCII lowercasing, separator folding and re-encode.
// Builds at most one job per accepted byte. Depends on utf8n_pkg.
module utf8n_front import utf8n_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       q_full,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       job_wr,
	output utf8n_job_t job
);

	typedef struct packed {
		logic            is_sep;
		logic [2:0]      n;
		logic [3:0][7:0] bytes;
	} enc_t;

	function automatic logic [2:0] seq_size(input logic [7:0] lead);
		logic [2:0] s;
		s = 3'd0;
		if (lead[7:5] == 3'b110)
			s = 3'd2;
		else if (lead[7:4] == 4'b1110)
			s = 3'd3;
		else if (lead[7:3] == 5'b11110)
			s = 3'd4;
		return s;
	endfunction

	function automatic logic is_sep(input logic [20:0] v);
		logic r;
		if (v < 21'h80)
			r = (v >= 21'h09 && v <= 21'h0D) || v == 21'h20 || v == 21'h2C ||
				v == 21'h2E || v == 21'h21 || v == 21'h3F || v == 21'h3B || v == 21'h3A;
		else
			r = v == IDEO_SPACE || v == IDEO_COMMA || v == IDEO_STOP ||
				v == FW_COMMA || v == FW_SEMI || v == FW_COLON;
		return r;
	endfunction

	function automatic enc_t encode(input logic [20:0] cp);
		enc_t       e;
		logic [20:0] v;
		v = cp;
		e = '0;
		if (v >= FW_FIRST && v <= FW_LAST)
			v = v - FW_OFFSET;
		e.is_sep = is_sep(v);
		if (v >= 21'h41 && v <= 21'h5A)
			v = v + 21'h20;
		if (v <= 21'h7F) begin
			e.n        = 3'd1;
			e.bytes[0] = v[7:0];
		end else if (v <= 21'h7FF) begin
			e.n        = 3'd2;
			e.bytes[0] = {3'b110, v[10:6]};
			e.bytes[1] = {2'b10, v[5:0]};
		end else if (v <= 21'hFFFF) begin
			e.n        = 3'd3;
			e.bytes[0] = {4'b1110, v[15:12]};
			e.bytes[1] = {2'b10, v[11:6]};
			e.bytes[2] = {2'b10, v[5:0]};
		end else begin
			e.n        = 3'd4;
			e.bytes[0] = {5'b11110, v[20:18]};
			e.bytes[1] = {2'b10, v[17:12]};
			e.bytes[2] = {2'b10, v[11:6]};
			e.bytes[3] = {2'b10, v[5:0]};
		end
		return e;
	endfunction

	logic [7:0] lead_q;
	logic [7:0] cont0_q;
	logic [7:0] cont1_q;
	logic [1:0] cnt_q;
	logic       pend_q;
	logic       started_q;

	logic            accept;
	logic [2:0]      size_h;
	logic [20:0]     v;
	logic [20:0]     minimum;
	logic            bad;
	logic [1:0]      nf;
	logic [2:0]      nt;
	logic [3:0][7:0] t;
	logic [2:0][7:0] f;
	logic            code_path;
	logic [20:0]     cp;
	enc_t            enc;
	logic            sep_hit;
	logic            hold_new;
	logic            store_cont;
	logic [1:0]      cnt_next;
	logic [3:0][7:0] body;
	logic [2:0]      body_n;
	logic            add_space;
	logic            pend_next;
	logic            started_next;
	logic [2:0]      ti;

	assign accept = push && !q_full;
	assign size_h = seq_size(lead_q);
	assign f      = {cont1_q, cont0_q, lead_q};

	// Code point of a completed sequence, plus its validity check
	always_comb begin
		unique case (size_h)
			3'd2: begin
				v       = {10'd0, lead_q[4:0], in_byte[5:0]};
				minimum = 21'h80;
			end
			3'd3: begin
				v       = {5'd0, lead_q[3:0], cont0_q[5:0], in_byte[5:0]};
				minimum = 21'h800;
			end
			default: begin
				v       = {lead_q[2:0], cont0_q[5:0], cont1_q[5:0], in_byte[5:0]};
				minimum = 21'h10000;
			end
		endcase
		bad = v < minimum || v > CP_MAX || (v >= SURR_LO && v <= SURR_HI);
	end

	always_comb begin
		nf         = 2'd0;
		nt         = 3'd0;
		t          = '0;
		code_path  = 1'b0;
		cp         = {13'd0, in_byte};
		hold_new   = 1'b0;
		store_cont = 1'b0;
		cnt_next   = cnt_q;
		if (cnt_q != 2'd0 && in_byte[7:6] == 2'b10) begin
			if ({1'b0, cnt_q} + 3'd1 >= size_h) begin
				cnt_next = 2'd0;
				if (bad) begin
					nf   = cnt_q;
					nt   = 3'd1;
					t[0] = in_byte;
				end else begin
					code_path = 1'b1;
					cp        = v;
				end
			end else if (end_of_text) begin
				// truncated at end: flush lead, held continuations and this byte
				nf   = cnt_q;
				nt   = 3'd1;
				t[0] = in_byte;
			end else begin
				store_cont = 1'b1;
				cnt_next   = cnt_q + 2'd1;
			end
		end else begin
			nf       = cnt_q;
			cnt_next = 2'd0;
			if (!in_byte[7]) begin
				code_path = 1'b1;
			end else if (seq_size(in_byte) != 3'd0 && !end_of_text) begin
				hold_new = 1'b1;
				cnt_next = 2'd1;
			end else begin
				nt   = 3'd1;
				t[0] = in_byte;
			end
		end
		enc     = encode(cp);
		sep_hit = code_path && enc.is_sep;
		if (code_path && !enc.is_sep) begin
			nt = enc.n;
			t  = enc.bytes;
		end
	end

	// Flushed held bytes first, then the tail
	always_comb begin
		body = '0;
		for (int i = 0; i < 4; i++) begin
			ti = 3'(i) - {1'b0, nf};
			if (3'(i) < {1'b0, nf})
				body[i] = f[i[1:0]];
			else if (ti < nt)
				body[i] = t[ti[1:0]];
		end
		body_n       = {1'b0, nf} + nt;
		add_space    = body_n != 3'd0 && pend_q && started_q;
		started_next = started_q || body_n != 3'd0;
		if (sep_hit)
			pend_next = started_q || nf != 2'd0;
		else if (body_n != 3'd0)
			pend_next = 1'b0;
		else
			pend_next = pend_q;
	end

	always_comb begin
		job          = '0;
		job.text_end = end_of_text;
		job.n        = body_n + {2'd0, add_space};
		if (add_space) begin
			job.bytes[0] = SPACE_BYTE;
			for (int i = 0; i < 4; i++)
				job.bytes[i+1] = body[i];
		end else begin
			for (int i = 0; i < 4; i++)
				job.bytes[i] = body[i];
		end
		job_wr = accept && (job.n != 3'd0 || end_of_text);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q    <= '0;
			cnt_q     <= '0;
			pend_q    <= 1'b0;
			started_q <= 1'b0;
		end else if (accept) begin
			if (end_of_text) begin
				lead_q    <= '0;
				cnt_q     <= '0;
				pend_q    <= 1'b0;
				started_q <= 1'b0;
			end else begin
				cnt_q     <= cnt_next;
				pend_q    <= pend_next;
				started_q <= started_next;
				if (hold_new)
					lead_q <= in_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && store_cont) begin
			if (cnt_q == 2'd1)
				cont0_q <= in_byte;
			else
				cont1_q <= in_byte;
		end
	end

endmodule

// ===== sv/utf8n_queue.sv =====
// Short job queue between the front end and the byte sequencer.
// Depends on utf8n_pkg.
module utf8n_queue import utf8n_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  utf8n_job_t wr_job,
	output logic       q_full,
	input  logic       rd,
	output utf8n_job_t rd_job,
	output logic       q_empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	utf8n_job_t            entries_q [Depth];
	logic [PtrW-1:0]       wr_ptr_q;
	logic [PtrW-1:0]       rd_ptr_q;
	logic [CntW-1:0]       count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign q_full  = count_q == CntW'(Depth);
	assign q_empty = count_q == '0;
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rd_job  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			entries_q[wr_ptr_q] <= wr_job;
	end

endmodule

// ===== sv/utf8n_back.sv =====
// Back end: walks each queued job one byte per cycle into the output register
// while that register is free or being popped. Depends on utf8n_pkg.
module utf8n_back import utf8n_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  utf8n_job_t head,
	input  logic       q_empty,
	output logic       q_rd,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       byte_present,
	output logic       text_end,
	output logic       run_last
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       present_q;
	logic       end_q;
	logic       last_q;
	logic [2:0] idx_q;

	logic take;
	logic is_last;

	assign take    = !q_empty && (!valid_q || pop);
	assign is_last = head.n == 3'd0 || idx_q == 3'(head.n - 3'd1);
	assign q_rd    = take && is_last;

	assign empty        = !valid_q;
	assign out_byte     = byte_q;
	assign byte_present = present_q;
	assign text_end     = end_q;
	assign run_last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (take) begin
			valid_q <= 1'b1;
			idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			last_q <= is_last;
			end_q  <= is_last && head.text_end;
			if (head.n == 3'd0) begin
				// empty end marker
				byte_q    <= '0;
				present_q <= 1'b0;
			end else begin
				byte_q    <= head.bytes[idx_q];
				present_q <= 1'b1;
			end
		end
	end

endmodule

// ===== sv/utf8n_checker.sv =====
// Port-level checks for the UTF-8 text normalizer, bound to the top level.
// Depends on utf8_text_normalizer_core_assert.svh.
`include "utf8_text_normalizer_core_assert.svh"

module utf8n_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       byte_present,
	input logic       text_end,
	input logic       run_last
);

	// the end marker carries no byte and closes the text
	`ASSERT_NOW(a_marker_form, !empty && !byte_present, out_byte == 8'h00 && text_end && run_last)
	// the final result of a text also closes its item
	`ASSERT_NOW(a_end_is_last, !empty && text_end, run_last)
	// an inserted space is always followed by a character of the same item
	`ASSERT_NOW(a_space_inner, !empty && byte_present && out_byte == 8'h20, !run_last && !text_end)
	// a waiting result holds until its transfer
	`ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(run_last))

endmodule

bind utf8_text_normalizer_core utf8n_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.out_byte     (out_byte),
	.byte_present (byte_present),
	.text_end     (text_end),
	.run_last     (run_last)
);
